### rtl/double_ended_queue_macros.svh
// Assertion macros for the deque block
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// check a consequence in the cycle after the antecedent
`define DEQ_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque check failed");

// check a consequence in the same cycle as the antecedent
`define DEQ_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque check failed");

`endif

### rtl/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int COUNT_W    = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        REQ_PUSH_BACK  = 2'd0,
        REQ_PUSH_FRONT = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_POP_BACK   = 2'd3
    } deq_req_type_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } deq_status_t;

    typedef struct packed {
        deq_req_type_t      req_type;
        logic signed [31:0] push_value;
    } deq_req_t;

    typedef struct packed {
        deq_status_t        status;
        logic signed [31:0] popped_value;
        logic [4:0]         fill_level;
    } deq_rsp_t;

    typedef struct packed {
        logic                  valid;
        logic [DATA_WIDTH-1:0] data;
    } deq_cell_t;

    typedef struct packed {
        logic                  push_front;
        logic                  push_back;
        logic                  pop_front;
        logic                  pop_back;
        logic [DATA_WIDTH-1:0] value;
    } deq_cell_op_t;

endpackage

### rtl/double_ended_queue.sv
`timescale 1ns / 1ps
// A request accepted at one edge gives its result, with done high, in the next cycle.
// Throughput: one request per cycle; busy is tied low, as every cell updates together.
// The popped value comes from the front cell or from the one cell that marks itself as tail.
// Reset: rst_n clears all cell valid flags, the fill count and done; the queue starts empty.
// The receiver cannot stall: each result is shown for exactly one cycle.

module double_ended_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  deq_pkg::deq_req_t req,
    output logic              done,
    output deq_pkg::deq_rsp_t rsp
);

    localparam int DEPTH   = deq_pkg::DEPTH;
    localparam int DW      = deq_pkg::DATA_WIDTH;
    localparam int COUNT_W = deq_pkg::COUNT_W;

    deq_pkg::deq_cell_t    cell_state [DEPTH];
    deq_pkg::deq_cell_t    cell_left  [DEPTH];
    deq_pkg::deq_cell_t    cell_right [DEPTH];
    logic [DW-1:0]         cell_tail  [DEPTH];
    deq_pkg::deq_cell_op_t op;

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               done_reg;
    deq_pkg::deq_rsp_t  rsp_reg;
    deq_pkg::deq_rsp_t  rsp_next;

    logic          fire;
    logic          full;
    logic          empty;
    logic [DW-1:0] tail_or;
    logic [DW-1:0] push_data;

    assign busy      = 1'b0;
    assign fire      = start && !busy;
    assign full      = (count_reg == COUNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign push_data = DW'($unsigned(req.push_value));

    always_comb
    begin
        op.push_front = fire && (req.req_type == deq_pkg::REQ_PUSH_FRONT) && !full;
        op.push_back  = fire && (req.req_type == deq_pkg::REQ_PUSH_BACK) && !full;
        op.pop_front  = fire && (req.req_type == deq_pkg::REQ_POP_FRONT) && !empty;
        op.pop_back   = fire && (req.req_type == deq_pkg::REQ_POP_BACK) && !empty;
        op.value      = push_data;
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                assign cell_left[gi] = '{valid: 1'b1, data: push_data};
            end
            else
            begin : g_mid_left
                assign cell_left[gi] = cell_state[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_last
                assign cell_right[gi] = '{valid: 1'b0, data: '0};
            end
            else
            begin : g_mid_right
                assign cell_right[gi] = cell_state[gi+1];
            end
            deq_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .op        (op),
                .left      (cell_left[gi]),
                .right     (cell_right[gi]),
                .state     (cell_state[gi]),
                .tail_data (cell_tail[gi])
            );
        end
    endgenerate

    always_comb
    begin
        tail_or = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            tail_or = tail_or | cell_tail[i];
        end
    end

    always_comb
    begin
        count_next            = count_reg;
        rsp_next.status       = deq_pkg::ST_OK;
        rsp_next.popped_value = '0;
        unique case (req.req_type)
            deq_pkg::REQ_PUSH_BACK,
            deq_pkg::REQ_PUSH_FRONT:
            begin
                if (full)
                begin
                    rsp_next.status = deq_pkg::ST_OVERFLOW;
                end
                else
                begin
                    count_next = count_reg + COUNT_W'(1);
                end
            end
            deq_pkg::REQ_POP_FRONT:
            begin
                if (empty)
                begin
                    rsp_next.status = deq_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    count_next            = count_reg - COUNT_W'(1);
                    rsp_next.popped_value = 32'(cell_state[0].data);
                end
            end
            deq_pkg::REQ_POP_BACK:
            begin
                if (empty)
                begin
                    rsp_next.status = deq_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    count_next            = count_reg - COUNT_W'(1);
                    rsp_next.popped_value = 32'(tail_or);
                end
            end
        endcase
        rsp_next.fill_level = 5'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= fire;
            if (fire)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

### rtl/deq_cell.sv
`timescale 1ns / 1ps

module deq_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  deq_pkg::deq_cell_op_t          op,
    input  deq_pkg::deq_cell_t             left,
    input  deq_pkg::deq_cell_t             right,
    output deq_pkg::deq_cell_t             state,
    output logic [deq_pkg::DATA_WIDTH-1:0] tail_data
);

    logic                           valid_reg;
    logic                           valid_next;
    logic [deq_pkg::DATA_WIDTH-1:0] data_reg;
    logic [deq_pkg::DATA_WIDTH-1:0] data_next;
    logic                           is_tail;

    assign is_tail = valid_reg && !right.valid;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (op.push_front)
        begin
            // shift away from the front
            valid_next = left.valid;
            data_next  = left.data;
        end
        else if (op.pop_front)
        begin
            // shift towards the front
            valid_next = right.valid;
            data_next  = right.data;
        end
        else if (op.push_back)
        begin
            if (!valid_reg && left.valid)
            begin
                valid_next = 1'b1;
                data_next  = op.value;
            end
        end
        else if (op.pop_back)
        begin
            if (is_tail)
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign state.valid = valid_reg;
    assign state.data  = data_reg;
    assign tail_data   = is_tail ? data_reg : '0;

endmodule

### rtl/deq_checker.sv
`timescale 1ns / 1ps
`include "double_ended_queue_macros.svh"

module deq_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input deq_pkg::deq_req_t req,
    input logic              done,
    input deq_pkg::deq_rsp_t rsp
);

    `DEQ_ASSERT_NEXT(a_result_follows, start && !busy, done)
    `DEQ_ASSERT_NEXT(a_no_spurious_result, !(start && !busy), !done)
    `DEQ_ASSERT_NOW(a_overflow_full, done && (rsp.status == deq_pkg::ST_OVERFLOW),
        rsp.fill_level == 5'(deq_pkg::DEPTH) && rsp.popped_value == '0)
    `DEQ_ASSERT_NOW(a_underflow_empty, done && (rsp.status == deq_pkg::ST_UNDERFLOW),
        rsp.fill_level == '0 && rsp.popped_value == '0)
    `DEQ_ASSERT_NEXT(a_push_no_value, start && !busy &&
        (req.req_type == deq_pkg::REQ_PUSH_BACK || req.req_type == deq_pkg::REQ_PUSH_FRONT),
        rsp.popped_value == '0 && rsp.status != deq_pkg::ST_UNDERFLOW)

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);
